@@ rtl/core/gn3_pkg.sv @@
`timescale 1ns / 1ps
// Package for the gradient noise core: widths, defaults and the permutation table.
// Used by both interfaces, gn3_hash, gn3_blend and the top level; depends on nothing.
package gn3_pkg;

	localparam int COORD_W      = 24;
	localparam int NOISE_W      = 18;
	localparam int NOISE_FRAC   = 16;
	localparam int CELL_W       = 8;
	localparam int DEF_FRAC_BITS = 16;

	// Reference permutation; the duplicated 512-entry ROM is this table indexed modulo 256.
	localparam logic [7:0] PERM [256] = '{
		8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13,
		8'd201, 8'd95, 8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225,
		8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
		8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148,
		8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
		8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
		8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87,
		8'd174, 8'd20, 8'd125, 8'd136, 8'd171, 8'd168, 8'd68, 8'd175,
		8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
		8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
		8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41,
		8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54,
		8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73,
		8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89, 8'd18, 8'd169,
		8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
		8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64,
		8'd52, 8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202,
		8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
		8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17,
		8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
		8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70,
		8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9,
		8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110,
		8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
		8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
		8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241,
		8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
		8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157,
		8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121, 8'd50, 8'd45,
		8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
		8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141,
		8'd128, 8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
	};

endpackage

@@ rtl/core/gn3_point_if.sv @@
`timescale 1ns / 1ps
// Input channel of the noise core: one 3D point per word.
// Depends on gn3_pkg for the coordinate width.
interface gn3_point_if;
	import gn3_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] x_coord;
	logic [COORD_W-1:0] y_coord;
	logic [COORD_W-1:0] z_coord;

	modport source (output valid, output x_coord, output y_coord, output z_coord, input ready);
	modport sink (input valid, input x_coord, input y_coord, input z_coord, output ready);
endinterface

@@ rtl/core/gn3_noise_if.sv @@
`timescale 1ns / 1ps
// Output channel of the noise core: one signed Q1.16 noise value per word.
// Depends on gn3_pkg for the result width.
interface gn3_noise_if;
	import gn3_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [NOISE_W-1:0] noise_value;

	modport source (output valid, output noise_value, input ready);
	modport sink (input valid, input noise_value, output ready);
endinterface

@@ rtl/core/gn3_fade.sv @@
`timescale 1ns / 1ps
// Three-stage quintic fade 6t^5 - 15t^4 + 10t^3 for one axis, products floored.
// Depends on nothing beyond its parameter; the fraction is delayed alongside.
module gn3_fade #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [FRAC_BITS-1:0]   frac,
	output logic [FRAC_BITS-1:0]   frac_s3,
	output logic signed [FRAC_BITS+1:0] fade_s3
);
	localparam int F = FRAC_BITS;
	localparam logic signed [F+4:0] K15 = (F+5)'(15) << F;
	localparam logic signed [F+4:0] K10 = (F+5)'(10) << F;

	logic [F+4:0]          six_t;
	logic signed [F+4:0]   lin;
	logic [F-1:0]          frac_s1, frac_s2;
	logic [2*F-1:0]        sq_s1;
	logic signed [2*F+5:0] m_s1;
	logic [2*F-1:0]        cube_s2;
	logic signed [F+4:0]   inner_s2;
	logic signed [2*F+5:0] fadep_s3;

	assign six_t = {4'b0, frac, 1'b0} + {3'b0, frac, 2'b0};
	assign lin   = $signed(six_t) - K15;

	always_ff @(posedge clk) begin
		if (en) begin
			frac_s1  <= frac;
			sq_s1    <= frac * frac;
			m_s1     <= $signed({1'b0, frac}) * lin;
			frac_s2  <= frac_s1;
			cube_s2  <= sq_s1[2*F-1:F] * frac_s1;
			inner_s2 <= (F+5)'(m_s1 >>> F) + K10;
			frac_s3  <= frac_s2;
			fadep_s3 <= $signed({1'b0, cube_s2[2*F-1:F]}) * inner_s2;
		end
	end

	assign fade_s3 = (F+2)'(fadep_s3 >>> F);
endmodule

@@ rtl/core/gn3_hash.sv @@
`timescale 1ns / 1ps
// Three-stage corner hash: one level of permutation lookups per stage.
// Depends on gn3_pkg for the permutation table.
module gn3_hash (
	input  logic                     clk,
	input  logic                     en,
	input  logic [gn3_pkg::CELL_W-1:0] x_cell,
	input  logic [gn3_pkg::CELL_W-1:0] y_cell,
	input  logic [gn3_pkg::CELL_W-1:0] z_cell,
	output logic [7:0][7:0]          hash_s3
);
	import gn3_pkg::*;

	logic [7:0] px0_s1, px1_s1, y_s1, z_s1;
	logic [7:0] a_idx, b_idx;
	logic [7:0] pa0_s2, pa1_s2, pb0_s2, pb1_s2, z_s2;
	logic [7:0] aa, ab, ba, bb;

	// The 512-entry ROM is the table twice, so every index wraps at 256.
	assign a_idx = px0_s1 + y_s1;
	assign b_idx = px1_s1 + y_s1;
	assign aa = pa0_s2 + z_s2;
	assign ab = pa1_s2 + z_s2;
	assign ba = pb0_s2 + z_s2;
	assign bb = pb1_s2 + z_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			px0_s1 <= PERM[x_cell];
			px1_s1 <= PERM[x_cell + 8'd1];
			y_s1   <= y_cell;
			z_s1   <= z_cell;
			pa0_s2 <= PERM[a_idx];
			pa1_s2 <= PERM[a_idx + 8'd1];
			pb0_s2 <= PERM[b_idx];
			pb1_s2 <= PERM[b_idx + 8'd1];
			z_s2   <= z_s1;
			hash_s3[0] <= PERM[aa];
			hash_s3[1] <= PERM[ba];
			hash_s3[2] <= PERM[ab];
			hash_s3[3] <= PERM[bb];
			hash_s3[4] <= PERM[aa + 8'd1];
			hash_s3[5] <= PERM[ba + 8'd1];
			hash_s3[6] <= PERM[ab + 8'd1];
			hash_s3[7] <= PERM[bb + 8'd1];
		end
	end
endmodule

@@ rtl/core/gn3_blend.sv @@
`timescale 1ns / 1ps
// Gradient dot products and the trilinear blend, stages four to eight.
// Depends on gn3_pkg for the result format.
module gn3_blend #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [7:0][7:0]              hash,
	input  logic [FRAC_BITS-1:0]         tx,
	input  logic [FRAC_BITS-1:0]         ty,
	input  logic [FRAC_BITS-1:0]         tz,
	input  logic signed [FRAC_BITS+1:0]  fu,
	input  logic signed [FRAC_BITS+1:0]  fv,
	input  logic signed [FRAC_BITS+1:0]  fw,
	output logic signed [gn3_pkg::NOISE_W-1:0] noise_s8
);
	import gn3_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int DW = F + 4;
	localparam int PW = F + 2 + DW;
	localparam logic signed [DW-1:0] ONE = DW'(1) << F;

	function automatic logic signed [DW-1:0] edge_dot(
		input logic [3:0] h,
		input logic signed [DW-1:0] px,
		input logic signed [DW-1:0] py,
		input logic signed [DW-1:0] pz
	);
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
		a = (h < 4'd8) ? px : py;
		b = (h < 4'd4) ? py : ((h == 4'd12 || h == 4'd14) ? px : pz);
		if (h[0]) a = -a;
		if (h[1]) b = -b;
		return a + b;
	endfunction

	logic signed [DW-1:0] x0, y0, z0, x1, y1, z1;
	logic signed [DW-1:0] dot_s4 [8];
	logic signed [F+1:0]  u_s4, v_s4, w_s4, v_s5, w_s5, w_s6;
	logic signed [DW-1:0] base_s5 [4];
	logic signed [PW-1:0] prod_s5 [4];
	logic signed [DW-1:0] lx [4];
	logic signed [DW-1:0] base_s6 [2];
	logic signed [PW-1:0] prod_s6 [2];
	logic signed [DW-1:0] ly [2];
	logic signed [DW-1:0] base_s7;
	logic signed [PW-1:0] prod_s7;
	logic signed [DW-1:0] r;

	assign x0 = DW'(tx);
	assign y0 = DW'(ty);
	assign z0 = DW'(tz);
	assign x1 = x0 - ONE;
	assign y1 = y0 - ONE;
	assign z1 = z0 - ONE;

	always_comb begin
		for (int k = 0; k < 4; k++) lx[k] = base_s5[k] + DW'(prod_s5[k] >>> F);
		for (int j = 0; j < 2; j++) ly[j] = base_s6[j] + DW'(prod_s6[j] >>> F);
		r = base_s7 + DW'(prod_s7 >>> F);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s4[0] <= edge_dot(hash[0][3:0], x0, y0, z0);
			dot_s4[1] <= edge_dot(hash[1][3:0], x1, y0, z0);
			dot_s4[2] <= edge_dot(hash[2][3:0], x0, y1, z0);
			dot_s4[3] <= edge_dot(hash[3][3:0], x1, y1, z0);
			dot_s4[4] <= edge_dot(hash[4][3:0], x0, y0, z1);
			dot_s4[5] <= edge_dot(hash[5][3:0], x1, y0, z1);
			dot_s4[6] <= edge_dot(hash[6][3:0], x0, y1, z1);
			dot_s4[7] <= edge_dot(hash[7][3:0], x1, y1, z1);
			u_s4 <= fu;
			v_s4 <= fv;
			w_s4 <= fw;
			for (int k = 0; k < 4; k++) begin
				base_s5[k] <= dot_s4[2*k];
				prod_s5[k] <= u_s4 * (dot_s4[2*k+1] - dot_s4[2*k]);
			end
			v_s5 <= v_s4;
			w_s5 <= w_s4;
			for (int j = 0; j < 2; j++) begin
				base_s6[j] <= lx[2*j];
				prod_s6[j] <= v_s5 * (lx[2*j+1] - lx[2*j]);
			end
			w_s6 <= w_s5;
			base_s7 <= ly[0];
			prod_s7 <= w_s6 * (ly[1] - ly[0]);
		end
	end

	// Rescale to sixteen fraction bits; the result wraps at the output width.
	generate
		if (F >= NOISE_FRAC) begin : g_down
			logic signed [DW-1:0] r_scaled;
			assign r_scaled = r >>> (F - NOISE_FRAC);
			always_ff @(posedge clk) begin
				if (en) noise_s8 <= NOISE_W'(r_scaled);
			end
		end else begin : g_up
			logic signed [NOISE_W-1:0] r_trunc;
			assign r_trunc = NOISE_W'(r);
			always_ff @(posedge clk) begin
				if (en) noise_s8 <= r_trunc << (NOISE_FRAC - F);
			end
		end
	endgenerate
endmodule

@@ rtl/core/gradient_noise_3d.sv @@
`timescale 1ns / 1ps
// Top level of the 3D gradient noise core: fade, hash and blend pipelines.
// Depends on gn3_pkg, gn3_point_if, gn3_noise_if, gn3_fade, gn3_hash, gn3_blend.
//
//   channel | direction | word
//   point   | in        | x_coord, y_coord, z_coord (unsigned, FRAC_BITS fraction bits)
//   noise   | out       | noise_value (signed Q1.16)
//
// One point enters per cycle while the pipeline is not held; its value is then registered at the output.
// The pipeline is three hash lookups in parallel with three fade stages, then five dot/lerp stages.
// Reset clears only the valid bits; the permutation table is a constant.
// When the output word is not taken the whole pipeline holds and point.ready falls.
module gradient_noise_3d #(
	parameter int FRAC_BITS = gn3_pkg::DEF_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	gn3_point_if.sink   point,
	gn3_noise_if.source noise
);
	import gn3_pkg::*;

	localparam int F = FRAC_BITS;

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic [COORD_W+CELL_W-1:0] xe, ye, ze;
	logic [F-1:0] tx_s3, ty_s3, tz_s3;
	logic signed [F+1:0] fu_s3, fv_s3, fw_s3;
	logic [7:0][7:0] hash_s3;
	logic signed [NOISE_W-1:0] noise_s8;

	assign en          = !vld_s8 || noise.ready;
	assign point.ready = en;

	// Padding above the coordinate gives a zero cell when there are no integer bits.
	assign xe = {{CELL_W{1'b0}}, point.x_coord};
	assign ye = {{CELL_W{1'b0}}, point.y_coord};
	assign ze = {{CELL_W{1'b0}}, point.z_coord};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= point.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	gn3_fade #(.FRAC_BITS(F)) u_fade_x (
		.clk(clk), .en(en), .frac(point.x_coord[F-1:0]), .frac_s3(tx_s3), .fade_s3(fu_s3)
	);
	gn3_fade #(.FRAC_BITS(F)) u_fade_y (
		.clk(clk), .en(en), .frac(point.y_coord[F-1:0]), .frac_s3(ty_s3), .fade_s3(fv_s3)
	);
	gn3_fade #(.FRAC_BITS(F)) u_fade_z (
		.clk(clk), .en(en), .frac(point.z_coord[F-1:0]), .frac_s3(tz_s3), .fade_s3(fw_s3)
	);

	gn3_hash u_hash (
		.clk(clk), .en(en),
		.x_cell(xe[F +: CELL_W]), .y_cell(ye[F +: CELL_W]), .z_cell(ze[F +: CELL_W]),
		.hash_s3(hash_s3)
	);

	gn3_blend #(.FRAC_BITS(F)) u_blend (
		.clk(clk), .en(en), .hash(hash_s3),
		.tx(tx_s3), .ty(ty_s3), .tz(tz_s3),
		.fu(fu_s3), .fv(fv_s3), .fw(fw_s3),
		.noise_s8(noise_s8)
	);

	assign noise.valid       = vld_s8;
	assign noise.noise_value = noise_s8;

	// The input is only refused while a finished word waits at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!point.ready |-> (noise.valid && !noise.ready))
		else $error("input stalled without a waiting output word");

	// A word in the last stage before the output moves on whenever the pipeline advances.
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s7 && en) |=> vld_s8)
		else $error("word lost between stage seven and the output");

	// The x and z fade weights of a valid word lie between zero and one.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (!fu_s3[F+1] && (fu_s3 <= ((F+2)'(1) << F))
			&& !fw_s3[F+1] && (fw_s3 <= ((F+2)'(1) << F))))
		else $error("fade weight out of range");
endmodule
